[sv/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk_i, off while rst_ni is low
`define OSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/osa_pkg.sv]
package osa_pkg;

  // func codes of an input request
  localparam logic [1:0] FUNC_SUBJ  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_COMP  = 2'd2;

  localparam int unsigned SIM_W  = 17;
  localparam int unsigned OUT_LW = 7;
  localparam int unsigned FRAC_W = 16;

  typedef enum logic [1:0] {
    OSA_OP_SUBJ,
    OSA_OP_QUERY,
    OSA_OP_COMP
  } osa_op_e;

  typedef struct packed {
    osa_op_e    op;
    logic [7:0] symbol;
  } osa_cmd_t;

  typedef struct packed {
    logic [OUT_LW-1:0] distance;
    logic [OUT_LW-1:0] longest_length;
    logic [SIM_W-1:0]  similarity_q16;
    logic              overflow;
  } osa_res_t;

  typedef enum logic [2:0] {
    OSA_IDLE,
    OSA_ROW_RD,
    OSA_ROW_LD,
    OSA_CELL_RD,
    OSA_CELL_EX,
    OSA_FINISH,
    OSA_DIV,
    OSA_OUT
  } osa_state_e;

endpackage

[sv/osa_if.sv]
// input request channel
interface osa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;
  modport source (output valid, output func, output symbol, input ready);
  modport sink (input valid, input func, input symbol, output ready);
endinterface

// result channel
interface osa_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  distance;
  logic [6:0]  longest_length;
  logic [16:0] similarity_q16;
  logic        overflow;
  modport source (output valid, output distance, output longest_length,
                  output similarity_q16, output overflow, input ready);
  modport sink (input valid, input distance, input longest_length,
                input similarity_q16, input overflow, output ready);
endinterface

[sv/osa_edit_similarity_core.sv]
// append request: enters a two-entry queue, stored at the edge it leaves it
// compute request: fills the matrix for strings of n and m characters cell by cell on
// the row store, then a restoring divider; one request at a time in the back end
// appends one per cycle while the back end is idle; output register on results
// rst_ni is asynchronous active low: clears lengths, flags, queue and result valid;
// character and row stores stay undefined until written
module osa_edit_similarity_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  osa_in_if.sink    in_i,
  osa_out_if.source out_o
);

  logic              cmd_valid, cmd_pop, res_valid, res_ready;
  osa_pkg::osa_cmd_t cmd;
  osa_pkg::osa_res_t res, res_q;
  logic              out_valid_q;

  osa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_symbol_i (in_i.symbol),
    .in_ready_o  (in_i.ready),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  osa_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.distance       = res_q.distance;
  assign out_o.longest_length = res_q.longest_length;
  assign out_o.similarity_q16 = res_q.similarity_q16;
  assign out_o.overflow       = res_q.overflow;

endmodule

[sv/osa_front.sv]
module osa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_func_i,
  input  logic [7:0]        in_symbol_i,
  output logic              in_ready_o,
  output logic              cmd_valid_o,
  output osa_pkg::osa_cmd_t cmd_o,
  input  logic              cmd_pop_i
);

  osa_pkg::osa_cmd_t fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              accept, push, pop;
  osa_pkg::osa_cmd_t cmd_in;

  // classify request, unused code is dropped
  always_comb begin
    cmd_in.symbol = in_symbol_i;
    cmd_in.op     = osa_pkg::OSA_OP_SUBJ;
    push          = 1'b0;
    unique case (in_func_i)
      osa_pkg::FUNC_SUBJ: begin
        cmd_in.op = osa_pkg::OSA_OP_SUBJ;
        push      = accept;
      end
      osa_pkg::FUNC_QUERY: begin
        cmd_in.op = osa_pkg::OSA_OP_QUERY;
        push      = accept;
      end
      osa_pkg::FUNC_COMP: begin
        cmd_in.op = osa_pkg::OSA_OP_COMP;
        push      = accept;
      end
      default: push = 1'b0;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  // two-entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

endmodule

[sv/osa_back.sv]
module osa_back #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  osa_pkg::osa_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  output osa_pkg::osa_res_t res_o,
  input  logic              res_ready_i
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned NW = LW + osa_pkg::FRAC_W;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam int unsigned RW = LW + 2;

  osa_pkg::osa_state_e state_q, state_d;

  logic [7:0]    subj_mem [MAX_LEN];
  logic [7:0]    qry_mem [MAX_LEN];
  logic [LW-1:0] row_mem [3 << LW];

  logic [LW-1:0] subj_len_q, qry_len_q;
  logic          ovf_q;
  logic [LW-1:0] i_q, j_q, left_q, diag_q, dist_q, longest_q;
  logic [7:0]    a_q, a_prev_q, b_prev_q;
  logic [1:0]    bank_cur_q, bank_prev_q, bank_prev2_q;
  logic [7:0]    s_rd_q, q_rd_q;
  logic [LW-1:0] p_rd_q, p2_rd_q;
  logic [LW:0]   rem_q;
  logic [NW-1:0] num_q, quo_q;
  logic [CW-1:0] cnt_q;

  logic          take, do_subj, do_qry, empty_str;
  logic          row_end, last_row;
  logic [AW-1:0] s_raddr, q_raddr;
  logic [RW-1:0] p_raddr, p2_raddr, wr_addr;
  logic [LW-1:0] up, p2, v_n, i_m1, j_m1, j_m2;
  logic [LW:0]   ins_del, sub, trans, v, rem_sh;
  logic          do_trans, qbit;

  // command decode
  assign take      = (state_q == osa_pkg::OSA_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take;
  assign do_subj   = take && (cmd_i.op == osa_pkg::OSA_OP_SUBJ);
  assign do_qry    = take && (cmd_i.op == osa_pkg::OSA_OP_QUERY);
  assign empty_str = (subj_len_q == '0) || (qry_len_q == '0);

  // memory addresses
  assign i_m1     = i_q - LW'(1);
  assign j_m1     = j_q - LW'(1);
  assign j_m2     = j_q - LW'(2);
  assign s_raddr  = i_m1[AW-1:0];
  assign q_raddr  = j_m1[AW-1:0];
  assign p_raddr  = {bank_prev_q, j_q};
  assign p2_raddr = {bank_prev2_q, j_m2};
  assign wr_addr  = {bank_cur_q, j_q};

  // one matrix cell, column zero of a row holds its row number
  always_comb begin
    up       = (i_q == LW'(1)) ? j_q : p_rd_q;
    p2       = (i_q == LW'(2)) ? j_m2 : ((j_q == LW'(2)) ? i_q - LW'(2) : p2_rd_q);
    ins_del  = ({1'b0, up} < {1'b0, left_q}) ? {1'b0, up} + 1'b1 : {1'b0, left_q} + 1'b1;
    sub      = {1'b0, diag_q} + {{LW{1'b0}}, (a_q != q_rd_q)};
    trans    = {1'b0, p2} + 1'b1;
    do_trans = (i_q > LW'(1)) && (j_q > LW'(1)) && (a_q == b_prev_q) && (a_prev_q == q_rd_q);
    v        = (sub < ins_del) ? sub : ins_del;
    if (do_trans && (trans < v)) v = trans;
    v_n      = v[LW-1:0];
  end

  assign row_end  = (j_q == qry_len_q);
  assign last_row = (i_q == subj_len_q);

  // restoring divider step
  assign rem_sh = {rem_q[LW-1:0], num_q[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, longest_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      osa_pkg::OSA_IDLE: begin
        if (take && (cmd_i.op == osa_pkg::OSA_OP_COMP)) begin
          state_d = empty_str ? osa_pkg::OSA_OUT : osa_pkg::OSA_ROW_RD;
        end
      end
      osa_pkg::OSA_ROW_RD:  state_d = osa_pkg::OSA_ROW_LD;
      osa_pkg::OSA_ROW_LD:  state_d = osa_pkg::OSA_CELL_RD;
      osa_pkg::OSA_CELL_RD: state_d = osa_pkg::OSA_CELL_EX;
      osa_pkg::OSA_CELL_EX: begin
        if (!row_end) state_d = osa_pkg::OSA_CELL_RD;
        else if (last_row) state_d = osa_pkg::OSA_FINISH;
        else state_d = osa_pkg::OSA_ROW_RD;
      end
      osa_pkg::OSA_FINISH:  state_d = osa_pkg::OSA_DIV;
      osa_pkg::OSA_DIV: begin
        if (cnt_q == CW'(1)) state_d = osa_pkg::OSA_OUT;
      end
      osa_pkg::OSA_OUT: begin
        if (res_ready_i) state_d = osa_pkg::OSA_IDLE;
      end
      default: state_d = osa_pkg::OSA_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res_valid_o          = (state_q == osa_pkg::OSA_OUT);
    res_o.distance       = osa_pkg::OUT_LW'(dist_q);
    res_o.longest_length = osa_pkg::OUT_LW'(longest_q);
    res_o.similarity_q16 = quo_q[osa_pkg::SIM_W-1:0];
    res_o.overflow       = ovf_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= osa_pkg::OSA_IDLE;
      subj_len_q <= '0;
      qry_len_q  <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_subj) begin
        if (subj_len_q == LW'(MAX_LEN)) ovf_q <= 1'b1;
        else subj_len_q <= subj_len_q + LW'(1);
      end
      if (do_qry) begin
        if (qry_len_q == LW'(MAX_LEN)) ovf_q <= 1'b1;
        else qry_len_q <= qry_len_q + LW'(1);
      end
      if ((state_q == osa_pkg::OSA_OUT) && res_ready_i) begin
        subj_len_q <= '0;
        qry_len_q  <= '0;
        ovf_q      <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      osa_pkg::OSA_IDLE: begin
        longest_q    <= (subj_len_q > qry_len_q) ? subj_len_q : qry_len_q;
        dist_q       <= '0;
        quo_q        <= '0;
        i_q          <= LW'(1);
        bank_cur_q   <= 2'd0;
        bank_prev_q  <= 2'd1;
        bank_prev2_q <= 2'd2;
      end
      osa_pkg::OSA_ROW_LD: begin
        a_q      <= s_rd_q;
        a_prev_q <= a_q;
        left_q   <= i_q;
        diag_q   <= i_m1;
        j_q      <= LW'(1);
      end
      osa_pkg::OSA_CELL_EX: begin
        left_q   <= v_n;
        diag_q   <= up;
        b_prev_q <= q_rd_q;
        dist_q   <= v_n;
        j_q      <= j_q + LW'(1);
        if (row_end && !last_row) begin
          i_q          <= i_q + LW'(1);
          bank_cur_q   <= bank_prev2_q;
          bank_prev_q  <= bank_cur_q;
          bank_prev2_q <= bank_prev_q;
        end
      end
      osa_pkg::OSA_FINISH: begin
        if (dist_q > longest_q) begin
          dist_q <= longest_q;
          num_q  <= '0;
        end else begin
          num_q <= {longest_q - dist_q, {osa_pkg::FRAC_W{1'b0}}};
        end
        rem_q <= '0;
        cnt_q <= CW'(NW);
      end
      osa_pkg::OSA_DIV: begin
        rem_q <= qbit ? rem_sh - {1'b0, longest_q} : rem_sh;
        num_q <= {num_q[NW-2:0], 1'b0};
        quo_q <= {quo_q[NW-2:0], qbit};
        cnt_q <= cnt_q - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // character and row stores
  always_ff @(posedge clk_i) begin
    if (do_subj && (subj_len_q != LW'(MAX_LEN))) subj_mem[subj_len_q[AW-1:0]] <= cmd_i.symbol;
    if (do_qry && (qry_len_q != LW'(MAX_LEN))) qry_mem[qry_len_q[AW-1:0]] <= cmd_i.symbol;
    if (state_q == osa_pkg::OSA_CELL_EX) row_mem[wr_addr] <= v_n;
    s_rd_q  <= subj_mem[s_raddr];
    q_rd_q  <= qry_mem[q_raddr];
    p_rd_q  <= row_mem[p_raddr];
    p2_rd_q <= row_mem[p2_raddr];
  end

endmodule

[sv/osa_checker.sv]
`include "assert_macros.svh"

module osa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  distance_i,
  input logic [6:0]  longest_length_i,
  input logic [16:0] similarity_q16_i
);

  // a waiting result stays until taken
  `OSA_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped")

  // similarity never above one
  `OSA_ASSERT_IMP(a_sim_range, out_valid_i, similarity_q16_i <= 17'h10000, "similarity too big")

  // distance bounded by the longer string
  `OSA_ASSERT_IMP(a_dist_range, out_valid_i, distance_i <= longest_length_i, "distance too big")

  // two empty strings give zero results
  `OSA_ASSERT_IMP(a_empty, out_valid_i && (longest_length_i == 7'd0),
    (distance_i == 7'd0) && (similarity_q16_i == 17'd0), "empty strings not zero")

endmodule

bind osa_edit_similarity_core osa_checker u_osa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .distance_i       (out_o.distance),
  .longest_length_i (out_o.longest_length),
  .similarity_q16_i (out_o.similarity_q16)
);

[sim/tb_osa_edit_similarity_core.sv]
`timescale 1ns / 1ps

module tb_osa_edit_similarity_core;

  localparam int unsigned STR_MAX = 64;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [6:0]  distance;
    logic [6:0]  longest_length;
    logic [16:0] similarity_q16;
    logic        overflow;
  } sim_res_t;

  // directed row: request plus optional typed-in result
  typedef struct {
    logic [1:0] func;
    logic [7:0] symbol;
    bit         typed;
    sim_res_t   res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  osa_in_if  req_if ();
  osa_out_if res_if ();

  osa_edit_similarity_core #(.MAX_LEN(STR_MAX)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] subj_str[STR_MAX];
  logic [7:0] query_str[STR_MAX];
  int unsigned subj_cnt, query_cnt;
  bit ovf_flag;
  sim_res_t result_q[$];
  int unsigned err_cnt, res_cnt, req_cnt;
  bit send_done, hold_off;

  // restricted edit distance over loaded strings
  function automatic int unsigned osa_dist();
    int unsigned r2[STR_MAX + 1], r1[STR_MAX + 1], rc[STR_MAX + 1];
    int unsigned v;
    for (int j = 0; j <= query_cnt; j++) r1[j] = j;
    for (int i = 1; i <= subj_cnt; i++) begin
      rc[0] = i;
      for (int j = 1; j <= query_cnt; j++) begin
        v = (r1[j] + 1 < rc[j-1] + 1) ? r1[j] + 1 : rc[j-1] + 1;
        if (r1[j-1] + (subj_str[i-1] != query_str[j-1]) < v)
          v = r1[j-1] + (subj_str[i-1] != query_str[j-1]);
        if (i > 1 && j > 1 && subj_str[i-1] == query_str[j-2] &&
            subj_str[i-2] == query_str[j-1] && r2[j-2] + 1 < v)
          v = r2[j-2] + 1;
        rc[j] = v;
      end
      r2 = r1;
      r1 = rc;
    end
    return r1[query_cnt];
  endfunction

  // apply one accepted request to the predictor
  function automatic void predict_request(logic [1:0] func, logic [7:0] symbol);
    sim_res_t r;
    int unsigned lng, d;
    longint unsigned s;
    case (func)
      osa_pkg::FUNC_SUBJ: begin
        if (subj_cnt < STR_MAX) begin
          subj_str[subj_cnt] = symbol;
          subj_cnt++;
        end else ovf_flag = 1'b1;
      end
      osa_pkg::FUNC_QUERY: begin
        if (query_cnt < STR_MAX) begin
          query_str[query_cnt] = symbol;
          query_cnt++;
        end else ovf_flag = 1'b1;
      end
      osa_pkg::FUNC_COMP: begin
        lng = (subj_cnt > query_cnt) ? subj_cnt : query_cnt;
        d = 0;
        s = 0;
        if (subj_cnt != 0 && query_cnt != 0) begin
          d = osa_dist();
          if (d > lng) d = lng;
          s = (longint'(lng - d) * 65536) / lng;
        end
        r.distance = d[6:0];
        r.longest_length = lng[6:0];
        r.similarity_q16 = s[16:0];
        r.overflow = ovf_flag;
        result_q.push_back(r);
        subj_cnt = 0;
        query_cnt = 0;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // result checking and receiver stalls
  initial begin
    sim_res_t e;
    int hold;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        res_cnt++;
        if (result_q.size() == 0) begin
          $error("unexpected result distance=%0d", res_if.distance);
          err_cnt++;
        end else begin
          e = result_q.pop_front();
          if (res_if.distance !== e.distance) begin
            $error("distance expected %0d actual %0d", e.distance, res_if.distance);
            err_cnt++;
          end
          if (res_if.longest_length !== e.longest_length) begin
            $error("longest_length expected %0d actual %0d", e.longest_length,
                   res_if.longest_length);
            err_cnt++;
          end
          if (res_if.similarity_q16 !== e.similarity_q16) begin
            $error("similarity_q16 expected %0d actual %0d", e.similarity_q16,
                   res_if.similarity_q16);
            err_cnt++;
          end
          if (res_if.overflow !== e.overflow) begin
            $error("overflow expected %0d actual %0d", e.overflow, res_if.overflow);
            err_cnt++;
          end
        end
      end
      if (hold_off && res_if.valid) begin
        // long hold-off while the sender keeps offering
        res_if.ready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk_i);
        hold_off = 1'b0;
        res_if.ready <= 1'b1;
      end else if (res_cnt > 30 && res_cnt < 60) res_if.ready <= 1'b1;
      else if ($urandom_range(0, 9) < 3)
        res_if.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ~res_if.ready;
      else res_if.ready <= 1'b1;
    end
  end

  dir_row_t dir_tab[$];

  function automatic dir_row_t mk(logic [1:0] f, logic [7:0] s, bit t = 0,
                                  int d = 0, int l = 0, int q = 0, bit o = 0);
    dir_row_t r;
    r.func = f;
    r.symbol = s;
    r.typed = t;
    r.res = {d[6:0], l[6:0], q[16:0], o};
    return r;
  endfunction

  // drive one request and wait for its acceptance
  task automatic send_request(logic [1:0] func, logic [7:0] symbol, bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= func;
    req_if.symbol <= symbol;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(func, symbol);
    req_cnt++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // one compute request over random strings
  task automatic random_pair(int unsigned maxl, bit gaps);
    int unsigned ns, nq, alpha;
    ns = $urandom_range(0, maxl);
    nq = $urandom_range(0, maxl);
    alpha = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 3);
    for (int k = 0; k < ns + nq; k++) begin
      if ($urandom_range(0, 40) == 0) send_request(FUNC_UNUSED, 8'($urandom), gaps);
      send_request((k < ns) ? osa_pkg::FUNC_SUBJ : osa_pkg::FUNC_QUERY,
                   8'($urandom_range(0, alpha)) ^ (alpha == 255 ? 8'd0 : 8'hA0), gaps);
    end
    send_request(osa_pkg::FUNC_COMP, 8'($urandom), gaps);
  endtask

  // stimulus
  initial begin
    req_if.valid = 1'b0;
    req_if.func = osa_pkg::FUNC_SUBJ;
    req_if.symbol = 8'd0;
    subj_cnt = 0;
    query_cnt = 0;
    ovf_flag = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty, one-sided, extremes, transposition, unused code
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'hFF, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h00));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'h00, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'hFF));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'h00, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'hFF));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'hFF));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'h55, 1, 0, 1, 65536, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h00));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'hFF));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'hAA, 1, 1, 1, 0, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h41));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h42));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'h42));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'h41));
    dir_tab.push_back(mk(FUNC_UNUSED, 8'h5A));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'h00, 1, 1, 2, 32768, 0));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h12));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h34));
    dir_tab.push_back(mk(osa_pkg::FUNC_SUBJ, 8'h56));
    dir_tab.push_back(mk(osa_pkg::FUNC_QUERY, 8'h12));
    dir_tab.push_back(mk(osa_pkg::FUNC_COMP, 8'h00));
    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].func, dir_tab[i].symbol, 0);
      if (dir_tab[i].typed) result_q[$] = dir_tab[i].res;
    end

    // full strings plus dropped appends, long receiver hold-off once the first result shows
    for (int k = 0; k < STR_MAX + 2; k++) send_request(osa_pkg::FUNC_SUBJ, 8'($urandom), 0);
    for (int k = 0; k < STR_MAX; k++) send_request(osa_pkg::FUNC_QUERY, 8'($urandom), 0);
    send_request(osa_pkg::FUNC_COMP, 8'h00, 0);
    hold_off = 1'b1;
    for (int k = 0; k < 40; k++) send_request(osa_pkg::FUNC_SUBJ, 8'h11, 0);
    send_request(osa_pkg::FUNC_QUERY, 8'h11, 0);
    send_request(osa_pkg::FUNC_COMP, 8'h00, 0);
    for (int k = 0; k < 3; k++) send_request(osa_pkg::FUNC_SUBJ, 8'($urandom), 0);
    for (int k = 0; k < STR_MAX + 1; k++) send_request(osa_pkg::FUNC_QUERY, 8'($urandom), 0);
    send_request(osa_pkg::FUNC_COMP, 8'h00, 0);

    // sender pause until everything is back
    wait_drained();

    // random part, mostly short strings
    while (req_cnt < 1900) begin
      random_pair(($urandom_range(0, 15) == 0) ? STR_MAX : 8, 1);
      if ($urandom_range(0, 30) == 0) wait_drained();
    end
    req_if.valid <= 1'b0;
    send_done = 1'b1;
  end

  // final report
  initial begin
    wait (send_done);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked incl. empty, full and transposed strings",
             req_cnt, res_cnt);
    if (err_cnt == 0 && result_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // timeout
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
